// ----- src/tlvf_pkg.sv -----
package tlvf_pkg;

    // width of a nesting level, enough for the deepest stack
    localparam int NEST_W = 4;
    // width of a buffer position or scope end
    localparam int POS_W = 17;

    // parse phase of the header walker
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG1,
        PH_TAG2,
        PH_TAGC,
        PH_LEN1,
        PH_LENX,
        PH_SKIP
    } t_phase;

    // input word: one buffer byte, with the start flag and length
    typedef struct packed {
        logic        start_req;
        logic [15:0] buffer_length;
        logic [7:0]  data_byte;
    } t_in_item;

    // result word: one per buffer whose search finishes
    typedef struct packed {
        logic              found;
        logic [15:0]       found_tag;
        logic              is_constructed;
        logic [15:0]       value_offset;
        logic [15:0]       value_length;
        logic [NEST_W-1:0] nest_level;
        logic              nest_overflow;
    } t_result;

    // parser to scope stack
    typedef struct packed {
        logic              upd;
        logic [NEST_W-1:0] lvl_base;
        logic              push;
        logic [POS_W-1:0]  push_end;
        logic [POS_W-1:0]  pos;
    } t_stack_cmd;

    // scope stack to parser
    typedef struct packed {
        logic [NEST_W-1:0] level;
        logic [POS_W-1:0]  top_end;
        logic [NEST_W-1:0] n_level;
    } t_stack_stat;

endpackage

// ----- src/tlvf_scope_stack.sv -----
module tlvf_scope_stack #(
    parameter int NEST_DEPTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlvf_pkg::t_stack_cmd i_cmd,
    output tlvf_pkg::t_stack_stat o_stat
);

    localparam int IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    logic [tlvf_pkg::POS_W-1:0]  r_stack [NEST_DEPTH];
    logic [tlvf_pkg::NEST_W-1:0] r_level;
    logic [tlvf_pkg::NEST_W-1:0] lvl_m1;
    logic [tlvf_pkg::NEST_W-1:0] lvl_after;
    logic [NEST_DEPTH-1:0]       keep;

    // end of the innermost open scope, then the parallel pop:
    // scopes still open past this byte form a prefix of the stack
    always_comb begin
        lvl_m1 = r_level - tlvf_pkg::NEST_W'(1);
        if (r_level == '0) begin
            o_stat.top_end = '0;
        end else begin
            o_stat.top_end = r_stack[lvl_m1[IDX_W-1:0]];
        end

        lvl_after = i_cmd.lvl_base + tlvf_pkg::NEST_W'(i_cmd.push);
        for (int i = 0; i < NEST_DEPTH; i++) begin
            if (i_cmd.push && (tlvf_pkg::NEST_W'(i) == i_cmd.lvl_base)) begin
                keep[i] = (tlvf_pkg::NEST_W'(i) < lvl_after) && (i_cmd.push_end > i_cmd.pos);
            end else begin
                keep[i] = (tlvf_pkg::NEST_W'(i) < lvl_after) && (r_stack[i] > i_cmd.pos);
            end
        end
        o_stat.n_level = tlvf_pkg::NEST_W'($countones(keep));
        o_stat.level   = r_level;
    end

    // scope end entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && i_cmd.push) begin
            r_stack[i_cmd.lvl_base[IDX_W-1:0]] <= i_cmd.push_end;
        end
    end

    // stack level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cmd.upd) begin
            r_level <= o_stat.n_level;
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= tlvf_pkg::NEST_W'(NEST_DEPTH))
        else $error("scope stack level beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && i_cmd.push) |-> (i_cmd.lvl_base < tlvf_pkg::NEST_W'(NEST_DEPTH)))
        else $error("push onto a full scope stack");

endmodule

// ----- src/tlvf_parser.sv -----
module tlvf_parser #(
    parameter int NEST_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  tlvf_pkg::t_in_item    i_item,
    input  logic [15:0]           i_target,
    input  tlvf_pkg::t_stack_stat i_stk,
    output tlvf_pkg::t_stack_cmd  o_stk,
    output logic                  o_res_valid,
    output tlvf_pkg::t_result     o_res
);

    // header walker state
    tlvf_pkg::t_phase            r_phase;
    logic                        r_done;
    logic                        r_ovf;
    logic [tlvf_pkg::POS_W-1:0]  r_pos;
    logic [tlvf_pkg::POS_W-1:0]  r_total;
    logic [15:0]                 r_tag;
    logic                        r_cons;
    logic [15:0]                 r_acc;
    logic [1:0]                  r_left;
    logic [tlvf_pkg::POS_W-1:0]  r_skip;

    // next values
    tlvf_pkg::t_phase            n_phase;
    tlvf_pkg::t_phase            n_phase_sel;
    logic                        n_done;
    logic                        n_ovf;
    logic [tlvf_pkg::POS_W-1:0]  n_total;
    logic [15:0]                 n_tag;
    logic                        n_cons;
    logic [15:0]                 n_acc;
    logic [1:0]                  n_left;
    logic [tlvf_pkg::POS_W-1:0]  n_skip;

    // working values of this byte
    logic                        start;
    logic                        active;
    logic                        empty;
    logic [7:0]                  b;
    tlvf_pkg::t_phase            ph_b;
    tlvf_pkg::t_phase            ph_y;
    logic [tlvf_pkg::POS_W-1:0]  pos_b;
    logic [tlvf_pkg::POS_W-1:0]  np;
    logic [tlvf_pkg::NEST_W-1:0] lvl_b;
    logic [15:0]                 tag_b;
    logic                        cons_b;
    logic [15:0]                 acc_b;
    logic [1:0]                  left_b;
    logic [tlvf_pkg::POS_W-1:0]  skip_b;
    logic [tlvf_pkg::POS_W-1:0]  scope_end;
    logic [tlvf_pkg::POS_W-1:0]  val_end;
    logic [15:0]                 len;
    logic                        hdr;
    logic                        bad;
    logic                        fail;
    logic                        fail_top;
    logic                        hit;
    logic                        push;
    logic                        data_skip;
    logic                        popped;
    logic                        close_top;
    logic                        finish;

    // decode of one byte against the header grammar and the scopes
    always_comb begin
        start  = i_item.start_req;
        active = i_fire && (start || !r_done);
        empty  = start && (i_item.buffer_length == '0);
        b      = i_item.data_byte;

        n_total = start ? {1'b0, i_item.buffer_length} : r_total;
        pos_b   = start ? '0 : r_pos;
        lvl_b   = start ? '0 : i_stk.level;
        tag_b   = start ? '0 : r_tag;
        cons_b  = start ? 1'b0 : r_cons;
        acc_b   = start ? '0 : r_acc;
        left_b  = start ? '0 : r_left;
        skip_b  = start ? '0 : r_skip;
        ph_b    = start ? tlvf_pkg::PH_TAG1 : r_phase;
        n_ovf   = start ? 1'b0 : r_ovf;

        np        = pos_b + tlvf_pkg::POS_W'(1);
        scope_end = (lvl_b == '0) ? n_total : i_stk.top_end;

        n_phase = ph_b;
        n_tag   = tag_b;
        n_cons  = cons_b;
        n_acc   = acc_b;
        n_left  = left_b;
        len     = '0;
        hdr     = 1'b0;
        bad     = 1'b0;

        unique case (ph_b)
            tlvf_pkg::PH_TAG1: begin
                n_tag   = {8'h00, b};
                n_cons  = b[5];
                n_phase = (b[4:0] == 5'h1F) ? tlvf_pkg::PH_TAG2 : tlvf_pkg::PH_LEN1;
            end
            tlvf_pkg::PH_TAG2: begin
                n_tag   = {tag_b[7:0], b};
                n_phase = b[7] ? tlvf_pkg::PH_TAGC : tlvf_pkg::PH_LEN1;
            end
            tlvf_pkg::PH_TAGC: begin
                if (!b[7]) begin
                    n_phase = tlvf_pkg::PH_LEN1;
                end
            end
            tlvf_pkg::PH_LEN1: begin
                if (!b[7]) begin
                    len = {8'h00, b};
                    hdr = 1'b1;
                end else if ((b[6:0] == 7'd1) || (b[6:0] == 7'd2)) begin
                    n_left  = b[1:0];
                    n_acc   = '0;
                    n_phase = tlvf_pkg::PH_LENX;
                end else begin
                    bad = 1'b1;
                end
            end
            tlvf_pkg::PH_LENX: begin
                n_acc  = {acc_b[7:0], b};
                n_left = left_b - 2'd1;
                if (n_left == 2'd0) begin
                    len = n_acc;
                    hdr = 1'b1;
                end
            end
            default: begin
                // skipped value byte, or no search running
            end
        endcase

        val_end   = np + tlvf_pkg::POS_W'(len);
        fail      = bad || (hdr && ((scope_end < np)
                    || (tlvf_pkg::POS_W'(len) > (scope_end - np))));
        fail_top  = fail && (lvl_b == '0);
        hit       = hdr && !fail && (n_tag == i_target);
        push      = hdr && !fail && !hit && n_cons
                    && (lvl_b < tlvf_pkg::NEST_W'(NEST_DEPTH));
        data_skip = hdr && !fail && !hit && !push;

        if (data_skip && n_cons) begin
            n_ovf = 1'b1;
        end

        if (fail) begin
            n_skip = scope_end;
        end else if (data_skip) begin
            n_skip = val_end;
        end else begin
            n_skip = skip_b;
        end

        if (fail || data_skip) begin
            ph_y = tlvf_pkg::PH_SKIP;
        end else if (push) begin
            ph_y = tlvf_pkg::PH_TAG1;
        end else begin
            ph_y = n_phase;
        end
        if ((ph_y == tlvf_pkg::PH_SKIP) && (np >= n_skip)) begin
            ph_y = tlvf_pkg::PH_TAG1;
        end

        // scope closing after the stack update
        popped    = i_stk.n_level < (lvl_b + tlvf_pkg::NEST_W'(push));
        close_top = (i_stk.n_level == '0) && (np >= n_total);
        finish    = active && (empty || fail_top || hit || close_top);
        n_done    = finish;
    end

    // next phase
    always_comb begin
        if (finish) begin
            n_phase_sel = tlvf_pkg::PH_IDLE;
        end else if (popped) begin
            n_phase_sel = tlvf_pkg::PH_TAG1;
        end else begin
            n_phase_sel = ph_y;
        end
    end

    // stack command and result word
    always_comb begin
        o_stk.upd      = active && !empty && !fail_top && !hit;
        o_stk.lvl_base = lvl_b;
        o_stk.push     = push;
        o_stk.push_end = val_end;
        o_stk.pos      = np;

        o_res_valid          = finish;
        o_res.found          = hit;
        o_res.found_tag      = hit ? n_tag : '0;
        o_res.is_constructed = hit && n_cons;
        o_res.value_offset   = hit ? np[15:0] : '0;
        o_res.value_length   = hit ? len : '0;
        o_res.nest_level     = hit ? lvl_b : '0;
        o_res.nest_overflow  = n_ovf;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlvf_pkg::PH_IDLE;
            r_done  <= 1'b1;
            r_ovf   <= 1'b0;
        end else if (active) begin
            r_phase <= n_phase_sel;
            r_done  <= n_done;
            r_ovf   <= n_ovf;
        end
    end

    // header and position registers, loaded on every active byte
    always_ff @(posedge i_clk) begin
        if (active) begin
            r_pos   <= np;
            r_total <= n_total;
            r_tag   <= n_tag;
            r_cons  <= n_cons;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_skip  <= n_skip;
        end
    end

    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_done)
        else $error("search still running after its result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_phase == tlvf_pkg::PH_IDLE))
        else $error("finished search left in a parse phase");

endmodule

// ----- src/ber_tlv_tag_finder.sv -----
// BER-TLV tag finder. Takes one buffer byte per word on the input channel and
// walks the elements depth first, entering constructed values and skipping
// primitive ones, until it meets the first element whose tag equals the
// configured target tag. A word with start_req set begins a new buffer (and
// drops any search in progress); it carries byte 0 unless buffer_length is 0.
// One result word comes out per buffer not dropped: on the byte that completes the
// matching header, or on the byte that ends the search without a match. One
// byte is accepted every cycle while the result side takes its words; a byte
// passes an input register and the combinational header decode with its parallel
// scope-stack pop, and its result is then registered in the output register.
// Scopes nest up to NEST_DEPTH deep; deeper constructed values are skipped and
// nest_overflow is raised. Write target_tag only while no buffer is being
// searched. No clearing pass follows reset.
module ber_tlv_tag_finder #(
    parameter int NEST_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tlvf_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tlvf_pkg::t_result  o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    logic                  r_in_valid;
    tlvf_pkg::t_in_item    r_in_item;
    logic                  r_out_valid;
    tlvf_pkg::t_result     r_out;
    logic [15:0]           r_target;
    logic                  proc_fire;
    logic                  res_valid;
    tlvf_pkg::t_result     res;
    tlvf_pkg::t_stack_cmd  stk_cmd;
    tlvf_pkg::t_stack_stat stk_stat;

    // handshakes: a word is processed when the result register has room
    assign proc_fire   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc_fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // target tag register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid) begin
            r_target <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // header decode
    tlvf_parser #(
        .NEST_DEPTH(NEST_DEPTH)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (proc_fire),
        .i_item     (r_in_item),
        .i_target   (r_target),
        .i_stk      (stk_stat),
        .o_stk      (stk_cmd),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    // scope ends of the open constructed values
    tlvf_scope_stack #(
        .NEST_DEPTH(NEST_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (stk_cmd),
        .o_stat (stk_stat)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    a_result_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> proc_fire)
        else $error("result produced without a processed word");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with the result side free");

endmodule

// ----- sim/tlv_search_checker.sv -----
`timescale 1ns / 100ps

module tlv_search_checker #(
    parameter int NEST_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  tlvf_pkg::t_in_item    i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  tlvf_pkg::t_result     i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [15:0]           i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    import tlvf_pkg::*;

    localparam logic [4:0] TAG_MORE = 5'h1F;

    // shadow of the search state
    logic [15:0]       target_copy;
    logic [POS_W-1:0]  end_stack [NEST_DEPTH];
    logic [NEST_W-1:0] depth_now;
    logic [POS_W-1:0]  pos_now;
    logic [POS_W-1:0]  buf_len;
    logic [POS_W-1:0]  skip_to;
    t_phase            phase;
    logic [15:0]       tag_now;
    logic              tag_cons;
    logic [15:0]       len_acc;
    logic [1:0]        len_left;
    logic              idle_now;
    logic              ovf_now;

    t_result expected_hits[$];
    int      fails;

    // end of the innermost open scope
    function automatic logic [POS_W-1:0] current_end();
        if (depth_now > 0) begin
            return end_stack[depth_now - 1];
        end
        return buf_len;
    endfunction

    task automatic note_failure(input string msg);
        fails++;
        if (fails <= 40) begin
            $display("tb_check: %s at %0t", msg, $time);
        end
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            note_failure($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // end the search and queue the result it gives
    task automatic conclude(input logic hit, input logic [POS_W-1:0] offset,
                            input logic [15:0] vlen);
        t_result r;
        r.found          = hit;
        r.found_tag      = hit ? tag_now : 16'h0;
        r.is_constructed = hit ? tag_cons : 1'b0;
        r.value_offset   = hit ? offset[15:0] : 16'h0;
        r.value_length   = hit ? vlen : 16'h0;
        r.nest_level     = hit ? depth_now : '0;
        r.nest_overflow  = ovf_now;
        expected_hits.push_back(r);
        idle_now = 1'b1;
        phase    = PH_IDLE;
    endtask

    // advance the search by one buffer byte
    task automatic walk_byte(input t_in_item w);
        logic [7:0]       b;
        logic [POS_W-1:0] np;
        logic [POS_W-1:0] lim;
        logic [15:0]      vlen;
        logic             hdr_done;
        logic             bad;
        b        = w.data_byte;
        vlen     = 16'h0;
        hdr_done = 1'b0;
        bad      = 1'b0;
        if (w.start_req) begin
            buf_len   = {1'b0, w.buffer_length};
            pos_now   = '0;
            depth_now = '0;
            phase     = PH_TAG1;
            ovf_now   = 1'b0;
            idle_now  = 1'b0;
            tag_now   = 16'h0;
            tag_cons  = 1'b0;
            len_acc   = 16'h0;
            len_left  = 2'd0;
            skip_to   = '0;
            if (w.buffer_length == 16'h0) begin
                conclude(1'b0, '0, 16'h0);
                return;
            end
        end else if (idle_now) begin
            return;
        end
        np = pos_now + 1;

        // header decode
        case (phase)
            PH_TAG1: begin
                tag_now  = {8'h00, b};
                tag_cons = b[5];
                phase    = (b[4:0] == TAG_MORE) ? PH_TAG2 : PH_LEN1;
            end
            PH_TAG2: begin
                tag_now = {tag_now[7:0], b};
                phase   = b[7] ? PH_TAGC : PH_LEN1;
            end
            PH_TAGC: begin
                if (!b[7]) phase = PH_LEN1;
            end
            PH_LEN1: begin
                if (!b[7]) begin
                    vlen     = {8'h00, b};
                    hdr_done = 1'b1;
                end else if (b[6:0] == 7'd1 || b[6:0] == 7'd2) begin
                    len_left = b[1:0];
                    len_acc  = 16'h0;
                    phase    = PH_LENX;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_LENX: begin
                len_acc  = {len_acc[7:0], b};
                len_left = len_left - 2'd1;
                if (len_left == 2'd0) begin
                    vlen     = len_acc;
                    hdr_done = 1'b1;
                end
            end
            default: ;
        endcase
        pos_now = np;
        lim     = current_end();

        // value must fit inside the current scope
        if (hdr_done && (lim < np || {1'b0, vlen} > lim - np)) bad = 1'b1;

        if (bad) begin
            if (depth_now == 0) begin
                conclude(1'b0, '0, 16'h0);
                return;
            end
            skip_to = lim;
            phase   = PH_SKIP;
        end else if (hdr_done) begin
            if (tag_now == target_copy) begin
                conclude(1'b1, np, vlen);
                return;
            end
            if (tag_cons && depth_now < NEST_DEPTH) begin
                end_stack[depth_now] = np + vlen;
                depth_now++;
                phase = PH_TAG1;
            end else begin
                if (tag_cons) ovf_now = 1'b1;
                skip_to = np + vlen;
                phase   = PH_SKIP;
            end
        end

        if (phase == PH_SKIP && np >= skip_to) phase = PH_TAG1;

        // close every scope that ends on this byte
        while (np >= current_end()) begin
            if (depth_now == 0) begin
                conclude(1'b0, '0, 16'h0);
                return;
            end
            depth_now--;
            phase = PH_TAG1;
        end
    endtask

    // watch the three channels
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            target_copy = 16'h0;
            depth_now   = '0;
            pos_now     = '0;
            buf_len     = '0;
            skip_to     = '0;
            phase       = PH_IDLE;
            tag_now     = 16'h0;
            tag_cons    = 1'b0;
            len_acc     = 16'h0;
            len_left    = 2'd0;
            idle_now    = 1'b1;
            ovf_now     = 1'b0;
            fails       = 0;
            expected_hits.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) target_copy = i_cfg_data;
            if (i_in_valid && i_in_ready) walk_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    note_failure("result word with nothing expected");
                end else begin
                    want = expected_hits.pop_front();
                    check_field("found", i_out_data.found, want.found);
                    check_field("found_tag", i_out_data.found_tag, want.found_tag);
                    check_field("is_constructed", i_out_data.is_constructed,
                                want.is_constructed);
                    check_field("value_offset", i_out_data.value_offset,
                                want.value_offset);
                    check_field("value_length", i_out_data.value_length,
                                want.value_length);
                    check_field("nest_level", i_out_data.nest_level, want.nest_level);
                    check_field("nest_overflow", i_out_data.nest_overflow,
                                want.nest_overflow);
                end
            end
        end
        o_fail_count = fails;
        o_pending    = expected_hits.size();
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import tlvf_pkg::*;

    localparam int NEST_DEPTH  = 8;
    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 100;
    localparam logic [7:0] LEN_ONE_BYTE = 8'h81;
    localparam logic [7:0] LEN_TWO_BYTE = 8'h82;
    localparam logic [7:0] LEN_RESERVED = 8'h80;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_word   = '0;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_result     out_word;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_word  = 16'h0;
    logic        cfg_ready;
    int          fail_count;
    int          pending;

    bit          gaps_on    = 1'b0;
    bit          hold_req   = 1'b0;
    int          cycle_count = 0;
    int          words_sent  = 0;
    logic [15:0] target_now  = 16'h0;

    // scratch for building buffers, one queue per nesting level
    logic [7:0] nest_body [0:11][$];
    logic [7:0] nest_head [0:11][$];
    logic [7:0] tag_bytes[$];
    logic [7:0] frame[$];

    ber_tlv_tag_finder #(
        .NEST_DEPTH(NEST_DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_word)
    );

    tlv_search_checker #(
        .NEST_DEPTH(NEST_DEPTH)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // offer one word and wait for it to be taken
    task automatic send_word(input logic st, input logic [15:0] blen,
                             input logic [7:0] db);
        t_in_item w;
        w.start_req     = st;
        w.buffer_length = blen;
        w.data_byte     = db;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // stop sending and wait until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_target(input logic [15:0] v);
        // an empty buffer closes any search left open
        send_word(1'b1, 16'h0, 8'($urandom));
        drain();
        cfg_valid <= 1'b1;
        cfg_word  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        target_now = v;
    endtask

    // tag bytes for one element, sometimes the searched tag
    task automatic pick_tag(input bit want_cons);
        logic [7:0] f;
        logic [7:0] s;
        int         kind;
        tag_bytes.delete();
        if ($urandom_range(0, 3) == 0) begin
            if (target_now[15:8] == 8'h00) begin
                tag_bytes.push_back(target_now[7:0]);
            end else begin
                tag_bytes.push_back(target_now[15:8]);
                tag_bytes.push_back(target_now[7:0]);
                if (target_now[7]) tag_bytes.push_back(8'($urandom_range(0, 127)));
            end
            return;
        end
        kind = $urandom_range(0, 3);
        f    = 8'($urandom);
        f[5] = want_cons;
        if (kind < 2) begin
            if (f[4:0] == 5'h1F) f[0] = 1'b0;
            tag_bytes.push_back(f);
        end else begin
            f[4:0] = 5'h1F;
            s      = 8'($urandom);
            s[7]   = (kind == 3);
            tag_bytes.push_back(f);
            tag_bytes.push_back(s);
            if (kind == 3) begin
                repeat ($urandom_range(0, 1)) tag_bytes.push_back(8'h80 | 8'($urandom));
                tag_bytes.push_back(8'($urandom_range(0, 127)));
            end
        end
    endtask

    // tag and length, in a random legal form, onto level d
    task automatic emit_header(input int d, input int n);
        int form;
        form = $urandom_range(0, 3);
        foreach (tag_bytes[i]) nest_body[d].push_back(tag_bytes[i]);
        if (n < 128 && form < 2) begin
            nest_body[d].push_back(8'(n));
        end else if (n < 256 && form < 3) begin
            nest_body[d].push_back(LEN_ONE_BYTE);
            nest_body[d].push_back(8'(n));
        end else begin
            nest_body[d].push_back(LEN_TWO_BYTE);
            nest_body[d].push_back(8'(n >> 8));
            nest_body[d].push_back(8'(n));
        end
    endtask

    // well-formed buffer of random elements, optionally diving deep first
    task automatic build_frame(input int budget, input int dive_to);
        int depth;
        int made;
        int act;
        int n;
        depth = 0;
        made  = 0;
        nest_body[0].delete();
        while (made < budget || depth > 0) begin
            act = (depth < dive_to) ? 4 : $urandom_range(0, 9);
            if (depth > 0 && (act < 3 || made >= budget)) begin
                tag_bytes = nest_head[depth];
                emit_header(depth - 1, nest_body[depth].size());
                for (int i = 0; i < nest_body[depth].size(); i++) begin
                    nest_body[depth - 1].push_back(nest_body[depth][i]);
                end
                depth--;
            end else if (act < 6 && depth < 11) begin
                pick_tag(1'b1);
                nest_head[depth + 1] = tag_bytes;
                nest_body[depth + 1].delete();
                depth++;
                made += tag_bytes.size() + 1;
            end else begin
                pick_tag(1'b0);
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
                emit_header(depth, n);
                repeat (n) nest_body[depth].push_back(8'($urandom));
                made += tag_bytes.size() + 1 + n;
            end
        end
        frame = nest_body[0];
    endtask

    // send n words of the frame, random bytes past its end
    task automatic send_frame(input logic [15:0] blen, input int n);
        logic [7:0] db;
        if (n < 1) n = 1;
        for (int i = 0; i < n; i++) begin
            db = (i < frame.size()) ? frame[i] : 8'($urandom);
            send_word(i == 0, (i == 0) ? blen : 16'($urandom), db);
        end
    endtask

    // one buffer: mostly clean, some damaged or plain noise
    task automatic send_random_buffer();
        int mode;
        int sz;
        int idx;
        build_frame($urandom_range(2, 30),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : 0);
        sz   = frame.size();
        mode = $urandom_range(0, 19);
        if (mode <= 12) begin
            send_frame(16'(sz), sz);
        end else if (mode == 13) begin
            idx = $urandom_range(0, sz - 1);
            frame[idx] = 8'($urandom);
            send_frame(16'(sz), sz);
        end else if (mode == 14) begin
            // a reserved length code somewhere in the buffer
            idx = $urandom_range(0, sz - 1);
            frame[idx] = ($urandom_range(0, 1) == 0) ? LEN_RESERVED
                                                     : 8'($urandom_range(8'h83, 8'hFF));
            send_frame(16'(sz), sz);
        end else if (mode == 15) begin
            send_frame(16'((sz > 3) ? sz - $urandom_range(1, 3) : 1), sz);
        end else if (mode == 16) begin
            send_frame(16'(sz + $urandom_range(1, 5)), sz);
        end else if (mode == 17) begin
            send_frame(16'(sz), $urandom_range(1, sz));
        end else if (mode == 18) begin
            frame.delete();
            send_frame(16'($urandom), $urandom_range(1, 8));
        end else begin
            send_frame(16'h0, 1);
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [15:0] t;
        int          stop_at;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // word before any buffer is ignored
        send_word(1'b0, 16'hFFFF, 8'hFF);
        // empty buffer
        send_word(1'b1, 16'h0000, 8'hAB);
        // tag zero matches the reset target, trailing byte ignored
        send_word(1'b1, 16'd3, 8'h00);
        send_word(1'b0, 16'($urandom), 8'h01);
        send_word(1'b0, 16'($urandom), 8'h55);
        // reserved length code at top level
        send_word(1'b1, 16'd4, 8'h5A);
        send_word(1'b0, 16'($urandom), LEN_RESERVED);
        // long form value overruns the largest buffer
        send_word(1'b1, 16'hFFFF, 8'h5A);
        send_word(1'b0, 16'($urandom), LEN_TWO_BYTE);
        send_word(1'b0, 16'($urandom), 8'hFF);
        send_word(1'b0, 16'($urandom), 8'hFF);
        // unfinished buffer dropped by a new start
        send_word(1'b1, 16'd10, 8'h5A);
        send_word(1'b0, 16'($urandom), 8'h05);
        send_word(1'b1, 16'd2, 8'h01);
        send_word(1'b0, 16'($urandom), 8'h00);
        // inner and outer scopes closing on the same byte
        send_word(1'b1, 16'd5, 8'h61);
        send_word(1'b0, 16'($urandom), LEN_ONE_BYTE);
        send_word(1'b0, 16'($urandom), 8'h02);
        send_word(1'b0, 16'($urandom), 8'h41);
        send_word(1'b0, 16'($urandom), 8'h00);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: t = 16'hFFFF;
                1: t = 16'h0000;
                2: begin
                    t = 16'($urandom_range(0, 255));
                    if (t[4:0] == 5'h1F) t[0] = 1'b0;
                end
                3: t = {3'($urandom), 5'h1F, 8'($urandom)};
                default: t = 16'($urandom);
            endcase
            write_target(t);
            gaps_on = (ph < 4);
            if (ph == 2) hold_req = 1'b1;
            stop_at = words_sent + PHASE_WORDS;
            while (words_sent < stop_at) begin
                send_random_buffer();
                if ($urandom_range(0, 29) == 0) drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- ber_tlv_tag_finder.f -----
src/tlvf_pkg.sv
src/tlvf_scope_stack.sv
src/tlvf_parser.sv
src/ber_tlv_tag_finder.sv
sim/tlv_search_checker.sv
sim/tb.sv
